// ===== sv/suwf_pkg.sv =====
package suwf_pkg;

  // Shift kinds carried in the command field of a request beat.
  typedef enum logic [1:0] {
    CMD_SHL  = 2'd0,
    CMD_SHR  = 2'd1,
    CMD_SAR  = 2'd2,
    CMD_NONE = 2'd3
  } cmd_t;

  // Bit positions inside the five-bit flags word.
  localparam int unsigned FLAG_CF = 0;
  localparam int unsigned FLAG_PF = 1;
  localparam int unsigned FLAG_ZF = 2;
  localparam int unsigned FLAG_SF = 3;
  localparam int unsigned FLAG_OF = 4;

  localparam int unsigned DATA_W  = 16;
  localparam int unsigned BYTE_W  = 8;
  localparam int unsigned COUNT_W = 8;
  localparam int unsigned FLAGS_W = 5;
  // Wide enough to hold a shift distance of up to DATA_W positions.
  localparam int unsigned SHAMT_W = 5;

endpackage

// ===== sv/suwf_req_if.sv =====
interface suwf_req_if
  import suwf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [1:0]           cmd;
  logic                 is_word;
  logic [DATA_W-1:0]    operand_value;
  logic [COUNT_W-1:0]   shift_count;
  logic [FLAGS_W-1:0]   flags_in;

  modport source (
    output valid, cmd, is_word, operand_value, shift_count, flags_in,
    input  ready
  );
  modport sink (
    input  valid, cmd, is_word, operand_value, shift_count, flags_in,
    output ready
  );
endinterface

// ===== sv/suwf_rsp_if.sv =====
interface suwf_rsp_if
  import suwf_pkg::*;
();
  logic                 valid;
  logic                 ready;
  logic [DATA_W-1:0]    shifted_value;
  logic [FLAGS_W-1:0]   flags_out;
  logic                 was_written;

  modport source (
    output valid, shifted_value, flags_out, was_written,
    input  ready
  );
  modport sink (
    input  valid, shifted_value, flags_out, was_written,
    output ready
  );
endinterface

// ===== sv/shift_unit_with_flags_top.sv =====
// Shift unit with flags.
// A request beat on req carries a shift kind (logical left, logical right,
// arithmetic right), a byte or word width, the operand, an unmasked 8-bit
// count and the current flags. Each request gives exactly one response beat
// on rsp with the shifted value, the new flags and a written indication.
// A zero count or the unused command returns the masked operand with the
// flags untouched and the written indication low.
// The datapath is a three-stage pipeline: decode and count clamping, the
// barrel shift, then flag generation into the output register. One new
// request is taken every cycle while the response side keeps up.
// Each stage holds its beat while the stage after it is full and stalled, so
// a stall on rsp fills the empty stages first and only then lowers req.ready;
// nothing is dropped or duplicated.
// Reset clears the stage valid bits; the pipeline is empty and ready as soon
// as reset is released.
module shift_unit_with_flags_top
  import suwf_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  suwf_req_if.sink   req,
  suwf_rsp_if.source rsp
);

  // Stage enables, worked backwards from the response side.
  logic en1, en2, en3;
  logic v1, v2, v3;

  assign en3 = !v3 || rsp.ready;
  assign en2 = !v2 || en3;
  assign en1 = !v1 || en2;
  assign req.ready = en1;

  // Stage 1: decode, operand masking and count clamping.
  logic                noop1_next, kill1_next, neg1_next, one1_next;
  logic [DATA_W-1:0]   a1_next;
  logic [SHAMT_W-1:0]  amt1_next;
  cmd_t                cmd_in;
  logic [COUNT_W-1:0]  width_in;

  logic                noop1, kill1, neg1, one1, word1;
  cmd_t                cmd1;
  logic [DATA_W-1:0]   a1;
  logic [SHAMT_W-1:0]  amt1;
  logic [FLAGS_W-1:0]  fin1;

  always_comb begin
    cmd_in     = cmd_t'(req.cmd);
    width_in   = req.is_word ? COUNT_W'(DATA_W) : COUNT_W'(BYTE_W);
    a1_next    = req.is_word ? req.operand_value
                             : {{(DATA_W-BYTE_W){1'b0}}, req.operand_value[BYTE_W-1:0]};
    neg1_next  = req.is_word ? req.operand_value[DATA_W-1] : req.operand_value[BYTE_W-1];
    noop1_next = (req.shift_count == '0) || (cmd_in == CMD_NONE);
    one1_next  = (req.shift_count == COUNT_W'(1));
    kill1_next = 1'b0;
    amt1_next  = req.shift_count[SHAMT_W-1:0];
    if (cmd_in == CMD_SAR) begin
      // Arithmetic right saturates at the width: all sign bits, carry is sign.
      if (req.shift_count >= width_in) begin
        amt1_next = width_in[SHAMT_W-1:0];
      end
    end else if (req.shift_count > width_in) begin
      // Logical shifts past the width leave nothing, not even the carry.
      kill1_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
    end else if (en1) begin
      v1 <= req.valid;
    end
    if (en1) begin
      noop1 <= noop1_next;
      kill1 <= kill1_next;
      neg1  <= neg1_next;
      one1  <= one1_next;
      word1 <= req.is_word;
      cmd1  <= cmd_in;
      a1    <= a1_next;
      amt1  <= amt1_next;
      fin1  <= req.flags_in;
    end
  end

  // Stage 2: barrel shift; the carry is the last bit shifted out.
  logic [2*DATA_W:0]    rext;
  logic [2*DATA_W:0]    rsh;
  logic [2*DATA_W-1:0]  lsh;
  logic                 fill;
  logic [DATA_W-1:0]    mask1;
  logic [DATA_W-1:0]    res2_next;
  logic                 carry2_next;

  logic                 v2_unused_guard;
  logic                 noop2, neg2, one2, word2;
  cmd_t                 cmd2;
  logic [DATA_W-1:0]    res2;
  logic                 carry2;
  logic [FLAGS_W-1:0]   fin2;

  assign v2_unused_guard = 1'b0;

  always_comb begin
    fill  = (cmd1 == CMD_SAR) && neg1;
    mask1 = word1 ? {DATA_W{1'b1}} : {{(DATA_W-BYTE_W){1'b0}}, {BYTE_W{1'b1}}};
    // Right shifts: fill bits above the operand, a guard bit below it.
    rext  = {{DATA_W{fill}},
             (word1 ? a1 : {{(DATA_W-BYTE_W){fill}}, a1[BYTE_W-1:0]}),
             1'b0};
    rsh   = rext >> amt1;
    lsh   = {{DATA_W{1'b0}}, a1} << amt1;
    unique case (cmd1)
      CMD_SHL: begin
        res2_next   = lsh[DATA_W-1:0] & mask1;
        carry2_next = word1 ? lsh[DATA_W] : lsh[BYTE_W];
      end
      CMD_SHR, CMD_SAR: begin
        res2_next   = rsh[DATA_W:1] & mask1;
        carry2_next = rsh[0];
      end
      default: begin
        res2_next   = a1;
        carry2_next = 1'b0;
      end
    endcase
    if (noop1) begin
      res2_next   = a1;
      carry2_next = 1'b0;
    end else if (kill1 || v2_unused_guard) begin
      res2_next   = '0;
      carry2_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v2 <= 1'b0;
    end else if (en2) begin
      v2 <= v1;
    end
    if (en2) begin
      noop2  <= noop1;
      neg2   <= neg1;
      one2   <= one1;
      word2  <= word1;
      cmd2   <= cmd1;
      res2   <= res2_next;
      carry2 <= carry2_next;
      fin2   <= fin1;
    end
  end

  // Stage 3: flag generation into the output register.
  logic [FLAGS_W-1:0] flags3_next;
  logic               sign3;
  logic               of3;

  always_comb begin
    sign3 = word2 ? res2[DATA_W-1] : res2[BYTE_W-1];
    case (cmd2)
      CMD_SHL: of3 = carry2 ^ sign3;
      CMD_SHR: of3 = neg2;
      default: of3 = one2 ? 1'b0 : fin2[FLAG_OF];
    endcase
    flags3_next          = '0;
    flags3_next[FLAG_CF] = carry2;
    flags3_next[FLAG_PF] = ~^res2[BYTE_W-1:0];
    flags3_next[FLAG_ZF] = (res2 == '0);
    flags3_next[FLAG_SF] = sign3;
    flags3_next[FLAG_OF] = of3;
    if (noop2) begin
      flags3_next = fin2;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v3 <= 1'b0;
    end else if (en3) begin
      v3 <= v2;
    end
    if (en3) begin
      rsp.shifted_value <= res2;
      rsp.flags_out     <= flags3_next;
      rsp.was_written   <= !noop2;
    end
  end

  assign rsp.valid = v3;

endmodule

// ===== sv/suwf_checker.sv =====
module suwf_checker
  import suwf_pkg::*;
(
  input logic               clk,
  input logic               rst,
  input logic               rsp_valid,
  input logic               rsp_ready,
  input logic [DATA_W-1:0]  shifted_value,
  input logic [FLAGS_W-1:0] flags_out,
  input logic               was_written
);

  // A response beat stays offered until it is taken.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("response beat withdrawn while stalled");

  // A written result reports its zero flag from the value itself.
  a_zero_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && was_written |-> flags_out[FLAG_ZF] == (shifted_value == '0))
    else $error("zero flag disagrees with the shifted value");

  // A written result reports even parity of its low byte.
  a_parity_flag: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && was_written |-> flags_out[FLAG_PF] == ~^shifted_value[BYTE_W-1:0])
    else $error("parity flag disagrees with the shifted value");

  // The pipeline is empty straight after reset.
  a_reset_empty: assert property (@(posedge clk) rst |=> !rsp_valid)
    else $error("response valid after reset");

endmodule

bind shift_unit_with_flags_top suwf_checker u_suwf_checker (
  .clk           (clk),
  .rst           (rst),
  .rsp_valid     (rsp.valid),
  .rsp_ready     (rsp.ready),
  .shifted_value (rsp.shifted_value),
  .flags_out     (rsp.flags_out),
  .was_written   (rsp.was_written)
);
